[hdl/sise_pkg.sv]
// ----------------------------------------------------------------------------
// Small integer set engine package
// Shared constants, opcode codes and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none
package sise_pkg;

  localparam int unsigned SET_DEPTH_DEF = 16;
  localparam int unsigned OP_W          = 4;
  localparam int unsigned VAL_W         = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT   = 4'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 4'd1;
  localparam logic [OP_W-1:0] OP_CONTAINS = 4'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 4'd3;
  localparam logic [OP_W-1:0] OP_COMPARE  = 4'd4;
  localparam logic [OP_W-1:0] OP_UNION    = 4'd5;
  localparam logic [OP_W-1:0] OP_DIFF     = 4'd6;
  localparam logic [OP_W-1:0] OP_INTER    = 4'd7;
  localparam logic [OP_W-1:0] OP_SYMDIFF  = 4'd8;
  localparam logic [OP_W-1:0] OP_COPY     = 4'd9;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // One classified command travelling from front to back.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             tgt;
    logic [VAL_W-1:0] val;
  } cmd_t;

endpackage
`default_nettype wire

[hdl/sise_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sise_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[hdl/sise_front.sv]
// ----------------------------------------------------------------------------
// Set engine front end
// Accepts command beats and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sise_front (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       push,
  output logic                                            full,
  input  wire logic                                       tgt,
  input  wire logic [sise_pkg::OP_W-1:0]                  op,
  input  wire logic [sise_pkg::VAL_W-1:0]                 val,
  output logic                                            cmd_valid,
  output sise_pkg::cmd_t                                  cmd,
  input  wire logic                                       cmd_take
);

  sise_pkg::cmd_t q_r [2];
  logic           rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Pointer and fill arithmetic.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= '{op: op, tgt: tgt, val: val};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("front queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty queue with unequal pointers");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (rd_ptr_r == wr_ptr_r))
    else $error("full queue with unequal pointers");

endmodule
`default_nettype wire

[hdl/sise_back.sv]
// ----------------------------------------------------------------------------
// Set engine back end
// Sequences one command at a time over the two set stores with a single
// comparator, and pushes results into a two-entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none
module sise_back #(
  parameter int unsigned SET_DEPTH = sise_pkg::SET_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  input  wire sise_pkg::cmd_t                cmd,
  output logic                               cmd_take,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic signed [sise_pkg::VAL_W-1:0]  out_element,
  output logic                               out_element_valid,
  output logic [1:0]                         out_status,
  output logic [4:0]                         out_set_size,
  output logic                               out_is_equal,
  output logic                               out_is_subset,
  output logic                               out_is_proper_subset,
  output logic                               out_is_superset,
  output logic                               out_is_proper_superset,
  output logic                               out_last
);

  localparam int unsigned AW = $clog2(SET_DEPTH);
  localparam int unsigned CW = $clog2(SET_DEPTH + 1);
  localparam int unsigned MAXO = 32;

  typedef struct packed {
    logic [sise_pkg::VAL_W-1:0] element;
    logic                       element_valid;
    logic [1:0]                 status;
    logic [4:0]                 set_size;
    logic [4:0]                 flags;
    logic                       last;
  } res_t;

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_OUTER  = 11'b000_0000_0010,
    S_ORD    = 11'b000_0000_0100,
    S_OGET   = 11'b000_0000_1000,
    S_SRD    = 11'b000_0001_0000,
    S_SCMP   = 11'b000_0010_0000,
    S_DECIDE = 11'b000_0100_0000,
    S_KEEP   = 11'b000_1000_0000,
    S_MV     = 11'b001_0000_0000,
    S_MVW    = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  sise_pkg::cmd_t             c_r, c_nxt;
  logic [CW-1:0]              cnt_r [2];
  logic [CW-1:0]              cnt_nxt [2];
  logic [CW-1:0]              i_r, i_nxt, j_r, j_nxt;
  logic                       x_r, x_nxt;     // set being walked (outer)
  logic                       pass_r, pass_nxt;
  logic                       hit_r, hit_nxt;
  logic                       fl_sub_r, fl_sub_nxt, fl_sup_r, fl_sup_nxt;
  logic [5:0]                 nout_r, nout_nxt;
  logic [sise_pkg::VAL_W-1:0] key_r, key_nxt;
  logic                       held_r, held_nxt;
  logic [sise_pkg::VAL_W-1:0] held_v_r, held_v_nxt;
  logic [1:0]                 st_r, st_nxt;

  // RAM ports.
  logic                       we [2];
  logic [AW-1:0]              waddr [2];
  logic [sise_pkg::VAL_W-1:0] wdata [2];
  logic [AW-1:0]              raddr [2];
  logic [sise_pkg::VAL_W-1:0] rdata [2];

  for (genvar g = 0; g < 2; g++) begin : g_store
    sise_ram #(.WIDTH(sise_pkg::VAL_W), .DEPTH(SET_DEPTH)) u_ram (
      .clk(clk), .we(we[g]), .waddr(waddr[g]), .wdata(wdata[g]),
      .raddr(raddr[g]), .rdata(rdata[g])
    );
  end

  // Output queue of two result beats.
  res_t       oq_r [2];
  logic [1:0] ocnt_r;
  logic       ord_r, owr_r;
  logic       opush;
  res_t       opush_d;
  logic       opop;
  logic       oroom;

  assign oroom     = (ocnt_r != 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign opop      = out_pop && !out_empty;
  assign {out_element, out_element_valid, out_status, out_set_size,
          out_is_equal, out_is_subset, out_is_proper_subset, out_is_superset,
          out_is_proper_superset, out_last} = oq_r[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
      ord_r  <= 1'b0;
      owr_r  <= 1'b0;
    end else begin
      ocnt_r <= ocnt_r + {1'b0, opush} - {1'b0, opop};
      if (opush) owr_r <= ~owr_r;
      if (opop) ord_r <= ~ord_r;
    end
  end

  always_ff @(posedge clk) begin
    if (opush) oq_r[owr_r] <= opush_d;
  end

  logic                       t, o, xs, ys;
  logic [CW-1:0]              cx, cy;
  logic [sise_pkg::VAL_W-1:0] rx, ry;
  logic [4:0]                 tsz;
  logic                       stream;
  logic [sise_pkg::OP_W-1:0]  opc;

  assign t   = c_r.tgt;
  assign o   = ~c_r.tgt;
  assign opc = c_r.op;
  assign xs  = x_r;
  assign ys  = ~x_r;
  assign cx  = cnt_r[xs];
  assign cy  = cnt_r[ys];
  assign rx  = rdata[xs];
  assign ry  = rdata[ys];
  assign tsz = 5'(cnt_r[t]);
  assign stream = (opc == sise_pkg::OP_UNION) || (opc == sise_pkg::OP_DIFF) ||
                  (opc == sise_pkg::OP_INTER) || (opc == sise_pkg::OP_SYMDIFF);

  // Sequencer: a command walks its outer set x and, per element, scans the
  // other set y for a match, one comparison per visit of S_SRD and S_SCMP.
  // Single-value commands only scan the target, which is then y.
  always_comb begin
    state_nxt  = state_r;
    c_nxt      = c_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    x_nxt      = x_r;
    pass_nxt   = pass_r;
    hit_nxt    = hit_r;
    fl_sub_nxt = fl_sub_r;
    fl_sup_nxt = fl_sup_r;
    nout_nxt   = nout_r;
    key_nxt    = key_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    st_nxt     = st_r;
    cmd_take   = 1'b0;
    opush      = 1'b0;
    opush_d    = '0;
    for (int k = 0; k < 2; k++) begin
      we[k]    = 1'b0;
      waddr[k] = '0;
      wdata[k] = '0;
      raddr[k] = '0;
    end
    raddr[xs] = i_r[AW-1:0];
    raddr[ys] = j_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          c_nxt      = cmd;
          i_nxt      = '0;
          j_nxt      = '0;
          hit_nxt    = 1'b0;
          nout_nxt   = '0;
          held_nxt   = 1'b0;
          st_nxt     = sise_pkg::ST_OK;
          fl_sub_nxt = 1'b1;
          fl_sup_nxt = 1'b1;
          pass_nxt   = 1'b0;
          x_nxt      = cmd.tgt;
          key_nxt    = cmd.val;
          case (cmd.op)
            sise_pkg::OP_INSERT, sise_pkg::OP_REMOVE, sise_pkg::OP_CONTAINS: begin
              x_nxt     = ~cmd.tgt;
              state_nxt = S_SRD;
            end
            sise_pkg::OP_COPY: begin
              x_nxt     = ~cmd.tgt;
              state_nxt = S_OUTER;
            end
            sise_pkg::OP_COMPARE, sise_pkg::OP_UNION, sise_pkg::OP_DIFF,
            sise_pkg::OP_INTER, sise_pkg::OP_SYMDIFF: state_nxt = S_OUTER;
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // Fetch the next outer element, or finish this pass.
      S_OUTER: begin
        if (i_r >= cx) begin
          if ((opc == sise_pkg::OP_COMPARE || opc == sise_pkg::OP_SYMDIFF ||
               opc == sise_pkg::OP_UNION) && !pass_r) begin
            pass_nxt = 1'b1;
            x_nxt    = ~x_r;
            i_nxt    = '0;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_ORD;
        end
      end

      // The read of outer element i is in flight.
      S_ORD: state_nxt = S_OGET;

      S_OGET: begin
        key_nxt = rx;
        j_nxt   = '0;
        hit_nxt = 1'b0;
        if (opc == sise_pkg::OP_COPY) begin
          we[ys]    = 1'b1;
          waddr[ys] = i_r[AW-1:0];
          wdata[ys] = rx;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_OUTER;
        end else if (opc == sise_pkg::OP_UNION && !pass_r) begin
          // Every target element belongs to the union.
          state_nxt = S_KEEP;
        end else begin
          state_nxt = S_SRD;
        end
      end

      // Scan y for the key; the read of entry j lands in S_SCMP.
      S_SRD: begin
        if (j_r >= cy) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCMP;
        end
      end

      S_SCMP: begin
        if (ry == key_r) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DECIDE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SRD;
        end
      end

      S_DECIDE: begin
        if (opc == sise_pkg::OP_INSERT) begin
          if (hit_r) st_nxt = sise_pkg::ST_DUP;
          else if (cnt_r[t] >= CW'(SET_DEPTH)) st_nxt = sise_pkg::ST_FULL;
          else begin
            we[t]      = 1'b1;
            waddr[t]   = cnt_r[t][AW-1:0];
            wdata[t]   = key_r;
            cnt_nxt[t] = cnt_r[t] + 1'b1;
          end
          state_nxt = S_FIN;
        end else if (opc == sise_pkg::OP_CONTAINS) begin
          st_nxt    = hit_r ? sise_pkg::ST_OK : sise_pkg::ST_ABSENT;
          state_nxt = S_FIN;
        end else if (opc == sise_pkg::OP_REMOVE) begin
          if (!hit_r) begin
            st_nxt    = sise_pkg::ST_ABSENT;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_MV;
          end
        end else if (opc == sise_pkg::OP_COMPARE) begin
          if (!hit_r) begin
            if (pass_r) fl_sup_nxt = 1'b0;
            else fl_sub_nxt = 1'b0;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = S_OUTER;
        end else begin
          // Streamed: keep the element when membership matches the operation.
          if ((opc == sise_pkg::OP_INTER) ? hit_r : !hit_r) begin
            state_nxt = S_KEEP;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_OUTER;
          end
        end
      end

      // The newest kept element is held back so that it can carry the final
      // mark; the one it replaces leaves as an ordinary beat.
      S_KEEP: begin
        if (nout_r >= 6'(MAXO)) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_OUTER;
        end else if (!held_r || oroom) begin
          if (held_r) begin
            opush   = 1'b1;
            opush_d = '{element: held_v_r, element_valid: 1'b1,
                        status: sise_pkg::ST_OK, set_size: tsz,
                        flags: 5'd0, last: 1'b0};
          end
          held_nxt   = 1'b1;
          held_v_nxt = key_r;
          nout_nxt   = nout_r + 6'd1;
          i_nxt      = i_r + 1'b1;
          state_nxt  = S_OUTER;
        end
      end

      // Remove: close the gap at j, reading entry j+1 ahead of its move.
      S_MV: begin
        if (CW'(j_r + 1'b1) >= cnt_r[t]) begin
          cnt_nxt[t] = cnt_r[t] - 1'b1;
          state_nxt  = S_FIN;
        end else begin
          raddr[ys] = AW'(j_r + 1'b1);
          state_nxt = S_MVW;
        end
      end

      S_MVW: begin
        we[ys]    = 1'b1;
        waddr[ys] = j_r[AW-1:0];
        wdata[ys] = ry;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_MV;
      end

      // Final beat of this command.
      S_FIN: begin
        if (oroom) begin
          opush = 1'b1;
          if (stream && held_r) begin
            opush_d = '{element: held_v_r, element_valid: 1'b1,
                        status: sise_pkg::ST_OK, set_size: tsz,
                        flags: 5'd0, last: 1'b1};
          end else begin
            opush_d = '{element: '0, element_valid: 1'b0, status: st_r,
                        set_size: tsz, flags: 5'd0, last: 1'b1};
            case (opc)
              sise_pkg::OP_CLEAR: begin
                opush_d.set_size = 5'd0;
                cnt_nxt[t]       = '0;
              end
              sise_pkg::OP_COPY: begin
                opush_d.set_size = 5'(cnt_r[o]);
                cnt_nxt[t]       = cnt_r[o];
              end
              sise_pkg::OP_COMPARE: begin
                opush_d.flags = {fl_sub_r && cnt_r[t] == cnt_r[o], fl_sub_r,
                                 fl_sub_r && cnt_r[t] < cnt_r[o], fl_sup_r,
                                 fl_sup_r && cnt_r[t] > cnt_r[o]};
              end
              default: ;
            endcase
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      x_r      <= 1'b0;
      held_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r[0] <= cnt_nxt[0];
      cnt_r[1] <= cnt_nxt[1];
      x_r      <= x_nxt;
      held_r   <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r      <= c_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    pass_r   <= pass_nxt;
    hit_r    <= hit_nxt;
    fl_sub_r <= fl_sub_nxt;
    fl_sup_r <= fl_sup_nxt;
    nout_r   <= nout_nxt;
    key_r    <= key_nxt;
    held_v_r <= held_v_nxt;
    st_r     <= st_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) ocnt_r != 2'd3)
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    opush |-> (ocnt_r != 2'd2))
    else $error("result pushed into a full queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CW'(SET_DEPTH) && cnt_r[1] <= CW'(SET_DEPTH))
    else $error("set count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> (state_r == S_IDLE))
    else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");

endmodule
`default_nettype wire

[hdl/small_integer_set_engine_core.sv]
// ----------------------------------------------------------------------------
// Small integer set engine
// Two small insertion-ordered sets with membership and set algebra.
// ----------------------------------------------------------------------------
// Usage: command beats enter through push/full (opcode, target set,
// operand value) into a two-entry command queue. A sequencer works on one
// command at a time and writes result beats into a two-entry result queue,
// read through empty/pop. Every command gives one result beat, or
// for union, difference, intersection and symmetric difference one beat per
// element (at most 32), the final one marked by out_last.
// A search compares the key with the stored elements one at a time; remove
// then closes the gap by moving each later entry down one place. Compare and
// the streamed operations (union only on its second pass) search the other
// set once per walked element, all through the single comparator. Commands
// run one at a time; the next starts once the previous final beat has
// entered the result queue.
// When the receiver stalls, the result queue fills and the sequencer waits;
// the command queue then fills and full rises.
// Reset empties both queues and both sets; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module small_integer_set_engine_core #(
  parameter int unsigned SET_DEPTH = sise_pkg::SET_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [3:0]         in_opcode,
  input  wire logic               in_target_set,
  input  wire logic signed [31:0] in_operand_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      out_element,
  output logic                    out_element_valid,
  output logic [1:0]              out_status,
  output logic [4:0]              out_set_size,
  output logic                    out_is_equal,
  output logic                    out_is_subset,
  output logic                    out_is_proper_subset,
  output logic                    out_is_superset,
  output logic                    out_is_proper_superset,
  output logic                    out_last
);

  logic           cmd_valid, cmd_take;
  sise_pkg::cmd_t cmd;

  sise_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .tgt(in_target_set), .op(in_opcode), .val(in_operand_value),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  sise_back #(.SET_DEPTH(SET_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .out_empty(empty), .out_pop(pop),
    .out_element(out_element), .out_element_valid(out_element_valid),
    .out_status(out_status), .out_set_size(out_set_size),
    .out_is_equal(out_is_equal), .out_is_subset(out_is_subset),
    .out_is_proper_subset(out_is_proper_subset),
    .out_is_superset(out_is_superset),
    .out_is_proper_superset(out_is_proper_superset), .out_last(out_last)
  );

endmodule
`default_nettype wire

[sim/small_integer_set_engine_core_test.sv]
// ----------------------------------------------------------------------------
// Small integer set engine testbench
// Drives command beats through the push/full queue and checks every result
// beat against a behavioural model of the two sets, typed directed rows
// against the table's status and size. The directed table covers value
// extremes, every operation, duplicates, absent values, empty streams and
// spare opcodes; random commands mostly from a small pool fill, overlap, overflow sets.
// ----------------------------------------------------------------------------
`default_nettype none
module small_integer_set_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = sise_pkg::SET_DEPTH_DEF;
  localparam int          RAND_CMDS = 176;
  localparam int          IDLE_CAP  = 20000;
  localparam int          DRAIN_CYC = 200;

  // Spare opcodes, which the block answers without touching the sets.
  localparam logic [3:0] OP_SPARE_LO = 4'd10;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  localparam logic SET_A = 1'b0;
  localparam logic SET_B = 1'b1;

  typedef struct packed {
    logic [31:0] element;
    logic        element_valid;
    logic [1:0]  status;
    logic [4:0]  set_size;
    logic [4:0]  flags;
    logic        last;
  } beat_t;

  typedef struct {
    logic [3:0]  op;
    logic        tgt;
    logic [31:0] val;
    bit          typed;
    logic [1:0]  status;
    logic [4:0]  set_size;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [3:0]         in_opcode;
  logic               in_target_set;
  logic signed [31:0] in_operand_value;
  logic               empty;
  logic               pop;
  logic signed [31:0] out_element;
  logic               out_element_valid;
  logic [1:0]         out_status;
  logic [4:0]         out_set_size;
  logic               out_is_equal;
  logic               out_is_subset;
  logic               out_is_proper_subset;
  logic               out_is_superset;
  logic               out_is_proper_superset;
  logic               out_last;

  // Model state: both stores and their counts.
  logic [31:0] set_mem [2][DEPTH];
  int          set_cnt [2];

  beat_t    pending_beats[$];
  int       errors;
  int       cmds_sent;
  int       beats_seen;
  int       members_seen;
  int       full_hits;
  bit       stim_done;
  int       idle_cycles;
  dir_row_t dir_rows[24];
  logic [31:0] value_pool[20];

  small_integer_set_engine_core #(.SET_DEPTH(DEPTH)) u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .push                   (push),
    .full                   (full),
    .in_opcode              (in_opcode),
    .in_target_set          (in_target_set),
    .in_operand_value       (in_operand_value),
    .empty                  (empty),
    .pop                    (pop),
    .out_element            (out_element),
    .out_element_valid      (out_element_valid),
    .out_status             (out_status),
    .out_set_size           (out_set_size),
    .out_is_equal           (out_is_equal),
    .out_is_subset          (out_is_subset),
    .out_is_proper_subset   (out_is_proper_subset),
    .out_is_superset        (out_is_superset),
    .out_is_proper_superset (out_is_proper_superset),
    .out_last               (out_last)
  );

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Returns the position of v in set s, or the count when it is absent.
  function automatic int find_pos(int s, logic [31:0] v);
    for (int i = 0; i < set_cnt[s]; i++) begin
      if (set_mem[s][i] == v) return i;
    end
    return set_cnt[s];
  endfunction

  function automatic bit is_member(int s, logic [31:0] v);
    return find_pos(s, v) < set_cnt[s];
  endfunction

  function automatic bit all_members_in(int x, int y);
    for (int i = 0; i < set_cnt[x]; i++) begin
      if (!is_member(y, set_mem[x][i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one command to the model sets and returns the beats it causes.
  task automatic apply_set_cmd(input logic [3:0] op, input logic tgt,
                               input logic [31:0] val, output beat_t beats[$]);
    int          t;
    int          o;
    int          pos;
    bit          sub;
    bit          sup;
    logic [1:0]  st;
    logic [4:0]  fl;
    logic [31:0] members[$];
    beat_t       b;
    t = tgt;
    o = 1 - t;
    st = sise_pkg::ST_OK;
    fl = '0;
    beats = {};
    members = {};
    case (op)
      sise_pkg::OP_INSERT: begin
        if (is_member(t, val)) begin
          st = sise_pkg::ST_DUP;
        end else if (set_cnt[t] >= DEPTH) begin
          st = sise_pkg::ST_FULL;
          full_hits++;
        end else begin
          set_mem[t][set_cnt[t]] = val;
          set_cnt[t]++;
        end
      end
      sise_pkg::OP_REMOVE: begin
        pos = find_pos(t, val);
        if (pos >= set_cnt[t]) begin
          st = sise_pkg::ST_ABSENT;
        end else begin
          for (int i = pos; i + 1 < set_cnt[t]; i++) set_mem[t][i] = set_mem[t][i + 1];
          set_cnt[t]--;
        end
      end
      sise_pkg::OP_CONTAINS: st = is_member(t, val) ? sise_pkg::ST_OK : sise_pkg::ST_ABSENT;
      sise_pkg::OP_CLEAR:    set_cnt[t] = 0;
      sise_pkg::OP_COMPARE: begin
        sub = all_members_in(t, o);
        sup = all_members_in(o, t);
        fl = {sub && set_cnt[t] == set_cnt[o], sub, sub && set_cnt[t] < set_cnt[o],
              sup, sup && set_cnt[t] > set_cnt[o]};
      end
      sise_pkg::OP_UNION: begin
        for (int i = 0; i < set_cnt[t]; i++) members.push_back(set_mem[t][i]);
        for (int i = 0; i < set_cnt[o]; i++) begin
          if (!is_member(t, set_mem[o][i])) members.push_back(set_mem[o][i]);
        end
      end
      sise_pkg::OP_DIFF, sise_pkg::OP_INTER: begin
        for (int i = 0; i < set_cnt[t]; i++) begin
          if (is_member(o, set_mem[t][i]) == (op == sise_pkg::OP_INTER))
            members.push_back(set_mem[t][i]);
        end
      end
      sise_pkg::OP_SYMDIFF: begin
        for (int i = 0; i < set_cnt[t]; i++) begin
          if (!is_member(o, set_mem[t][i])) members.push_back(set_mem[t][i]);
        end
        for (int i = 0; i < set_cnt[o]; i++) begin
          if (!is_member(t, set_mem[o][i])) members.push_back(set_mem[o][i]);
        end
      end
      sise_pkg::OP_COPY: begin
        set_mem[t] = set_mem[o];
        set_cnt[t] = set_cnt[o];
      end
      default: ;
    endcase

    // Streamed answers give one beat per member, at most 32; everything else, and an empty stream, gives one.
    if (members.size() > 0) begin
      while (members.size() > 32) void'(members.pop_back());
      foreach (members[k]) begin
        b = '{members[k], 1'b1, sise_pkg::ST_OK, 5'(set_cnt[t]), 5'b0,
              k == members.size() - 1};
        beats.push_back(b);
      end
    end else begin
      b = '{32'd0, 1'b0, st, 5'(set_cnt[t]), fl, 1'b1};
      beats.push_back(b);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Sends one command beat, with a random gap in front when asked.
  task automatic send_cmd(input logic [3:0] op, input logic tgt, input logic [31:0] val,
                          input int gap, input bit typed, input logic [1:0] st,
                          input logic [4:0] sz);
    beat_t beats[$];
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push             <= 1'b1;
    in_opcode        <= op;
    in_target_set    <= tgt;
    in_operand_value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_set_cmd(op, tgt, val, beats);
    if (typed) pending_beats.push_back(beat_t'{32'd0, 1'b0, st, sz, 5'b0, 1'b1});
    else foreach (beats[k]) pending_beats.push_back(beats[k]);
    cmds_sent++;
  endtask

  // Stimulus: directed table first, then random commands.
  initial begin
    int          gap;
    bit          burst;
    int          pick;
    logic [3:0]  op;
    logic [31:0] val;
    rst_n = 1'b0;
    push = 1'b0;
    in_opcode = '0;
    in_target_set = 1'b0;
    in_operand_value = '0;
    errors = 0;
    cmds_sent = 0;
    beats_seen = 0;
    members_seen = 0;
    full_hits = 0;
    stim_done = 1'b0;
    set_cnt[0] = 0;
    set_cnt[1] = 0;
    value_pool = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1, 32'h2,
                   32'h3, 32'h5, 32'h8, 32'hd, 32'h15, 32'h22, 32'h37, 32'h59,
                   32'haaaa_5555, 32'h5555_aaaa, 32'hffff_fffe, 32'h8000_0001,
                   32'h7fff_fffe, 32'h1234_5678};
    dir_rows = '{
      '{sise_pkg::OP_CONTAINS, SET_A, 32'h0,         1, sise_pkg::ST_ABSENT, 5'd0},
      '{sise_pkg::OP_REMOVE,   SET_B, 32'h5,         1, sise_pkg::ST_ABSENT, 5'd0},
      '{sise_pkg::OP_INSERT,   SET_A, 32'h7fff_ffff, 1, sise_pkg::ST_OK,     5'd1},
      '{sise_pkg::OP_INSERT,   SET_A, 32'h8000_0000, 1, sise_pkg::ST_OK,     5'd2},
      '{sise_pkg::OP_INSERT,   SET_A, 32'h8000_0000, 1, sise_pkg::ST_DUP,    5'd2},
      '{sise_pkg::OP_INSERT,   SET_A, 32'hffff_ffff, 1, sise_pkg::ST_OK,     5'd3},
      '{sise_pkg::OP_INSERT,   SET_B, 32'h0,         1, sise_pkg::ST_OK,     5'd1},
      '{sise_pkg::OP_INSERT,   SET_B, 32'hffff_ffff, 1, sise_pkg::ST_OK,     5'd2},
      '{sise_pkg::OP_COMPARE,  SET_A, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_UNION,    SET_A, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_DIFF,     SET_A, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_INTER,    SET_A, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_SYMDIFF,  SET_A, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_COMPARE,  SET_B, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_CONTAINS, SET_A, 32'hffff_ffff, 1, sise_pkg::ST_OK,     5'd3},
      '{sise_pkg::OP_REMOVE,   SET_A, 32'h7fff_ffff, 1, sise_pkg::ST_OK,     5'd2},
      '{sise_pkg::OP_COPY,     SET_B, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_COMPARE,  SET_A, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_CLEAR,    SET_B, 32'h0,         1, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_UNION,    SET_B, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_INTER,    SET_B, 32'h0,         0, sise_pkg::ST_OK,     5'd0},
      '{OP_SPARE_HI,           SET_A, 32'hffff_ffff, 1, sise_pkg::ST_OK,     5'd2},
      '{OP_SPARE_LO,           SET_B, 32'h0,         1, sise_pkg::ST_OK,     5'd0},
      '{sise_pkg::OP_SYMDIFF,  SET_B, 32'h0,         0, sise_pkg::ST_OK,     5'd0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_cmd(dir_rows[r].op, dir_rows[r].tgt, dir_rows[r].val, $urandom_range(0, 7),
               dir_rows[r].typed, dir_rows[r].status, dir_rows[r].set_size);
    end

    // Random part: inserts dominate so the stores reach full, values come
    // mostly from a small pool so that the two sets overlap.
    burst = 1'b0;
    for (int n = 0; n < RAND_CMDS; n++) begin
      if (n % 20 == 0) burst = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 38)      op = sise_pkg::OP_INSERT;
      else if (pick < 52) op = sise_pkg::OP_REMOVE;
      else if (pick < 60) op = sise_pkg::OP_CONTAINS;
      else if (pick < 63) op = sise_pkg::OP_CLEAR;
      else if (pick < 70) op = sise_pkg::OP_COMPARE;
      else if (pick < 91) op = 4'($urandom_range(sise_pkg::OP_UNION, sise_pkg::OP_SYMDIFF));
      else if (pick < 95) op = sise_pkg::OP_COPY;
      else                op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if ($urandom_range(0, 9) == 0) val = $urandom;
      else val = value_pool[$urandom_range(0, 19)];
      gap = burst ? 0 : $urandom_range(0, 7);
      send_cmd(op, 1'($urandom_range(0, 1)), val, gap, 1'b0, sise_pkg::ST_OK, 5'd0);
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls, then each beat is checked against the oldest
  // expectation.
  initial begin
    int    stall;
    bit    burst;
    beat_t exp_b;
    beat_t act_b;
    pop = 1'b0;
    burst = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      stall = burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      act_b = '{out_element, out_element_valid, out_status, out_set_size,
                {out_is_equal, out_is_subset, out_is_proper_subset, out_is_superset,
                 out_is_proper_superset}, out_last};
      beats_seen++;
      if (out_element_valid) members_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t ns: unexpected beat, actual %p", $realtime, act_b);
        errors++;
      end else begin
        exp_b = pending_beats.pop_front();
        check_field("element", exp_b.element, act_b.element);
        check_field("element_valid", 32'(exp_b.element_valid), 32'(act_b.element_valid));
        check_field("status", 32'(exp_b.status), 32'(act_b.status));
        check_field("set_size", 32'(exp_b.set_size), 32'(act_b.set_size));
        check_field("compare flags", 32'(exp_b.flags), 32'(act_b.flags));
        check_field("last", 32'(exp_b.last), 32'(act_b.last));
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_CAP) begin
        $display("%0t ns: no progress, %0d beats outstanding", $realtime,
                 pending_beats.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // End of run: drain, let trailing beats show up, then report.
  initial begin
    wait (stim_done);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("Sent %0d commands, checked %0d result beats (%0d set members).",
             cmds_sent, beats_seen, members_seen);
    $display("Inserts refused on a full store: %0d, mismatches: %0d.", full_hits, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
